// ===== src/mtc_pkg.sv =====
// Shared types and constants for the millisecond tick clock with calendar readout.
`timescale 1ns / 1ps
`default_nettype none

package mtc_pkg;

    // Command codes carried in the cmd field of an input beat.
    localparam logic CmdTick = 1'b0;
    localparam logic CmdLoad = 1'b1;

    // Milliseconds per second; the residue counter runs from 0 to MsPerSec - 1.
    localparam int unsigned MsPerSec = 1000;
    localparam int unsigned MsResW   = $clog2(MsPerSec);

    typedef struct packed {
        logic        cmd;
        logic [31:0] new_seconds;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] milli_count;
        logic [31:0] epoch_seconds;
        logic [5:0]  sec_of_minute;
        logic [5:0]  min_of_hour;
        logic [4:0]  hour_of_day;
        logic [2:0]  weekday;
        logic [11:0] cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_day;
    } t_out_beat;

    // Broken-down time produced by the converter.
    typedef struct packed {
        logic [5:0]  sec_of_minute;
        logic [5:0]  min_of_hour;
        logic [4:0]  hour_of_day;
        logic [2:0]  weekday;
        logic [11:0] cal_year;
        logic [3:0]  cal_month;
        logic [4:0]  cal_day;
    } t_cal;

    // Converter status towards the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } t_conv_stat;

endpackage

`default_nettype wire

// ===== src/mtc_conv.sv =====
// Iterative seconds-to-calendar converter built around one compare-and-subtract unit.
`timescale 1ns / 1ps
`default_nettype none

module mtc_conv (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [31:0]        i_secs,
    input  wire logic               i_ack,
    output mtc_pkg::t_conv_stat     o_stat,
    output mtc_pkg::t_cal           o_cal
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DAY,
        S_HOUR,
        S_MIN,
        S_WDAY,
        S_QUAD,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    localparam logic [31:0] SecsPerDay   = 32'd86400;
    localparam logic [31:0] SecsPerHour  = 32'd3600;
    localparam logic [31:0] SecsPerMin   = 32'd60;
    localparam logic [31:0] DaysPerWeek  = 32'd7;
    localparam logic [31:0] QuadLong     = 32'd1461;
    localparam logic [31:0] QuadShort    = 32'd1460;
    localparam logic [31:0] YearLong     = 32'd366;
    localparam logic [31:0] YearShort    = 32'd365;
    localparam logic [31:0] EpochWeekday = 32'd4;
    localparam logic [11:0] EpochYear    = 12'd1970;
    localparam logic [11:0] ShortQuadYr  = 12'd2098;
    localparam logic [11:0] NoLeapYear   = 12'd2100;
    localparam logic [3:0]  MonthFeb     = 4'd1;
    localparam logic [3:0]  MonthDec     = 4'd11;
    localparam logic [4:0]  FebLeapLen   = 5'd29;
    localparam logic [4:0]  MonthLen [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    t_state        r_state;
    logic [31:0]   r_acc;
    logic [3:0]    r_k;
    logic [15:0]   r_days;
    logic [11:0]   r_year;
    logic [3:0]    r_month;
    mtc_pkg::t_cal r_cal;

    logic [31:0]   n_sub;
    logic          n_ge;
    logic [31:0]   n_step;
    logic          n_leap;
    logic [4:0]    n_mlen;

    // Leap years within 1970..2106: every fourth year except 2100.
    assign n_leap = (r_year[1:0] == 2'd0) && (r_year != NoLeapYear);
    assign n_mlen = ((r_month == MonthFeb) && n_leap) ? FebLeapLen : MonthLen[r_month];

    always_comb begin
        case (r_state)
            S_DAY:   n_sub = SecsPerDay << r_k;
            S_HOUR:  n_sub = SecsPerHour << r_k;
            S_MIN:   n_sub = SecsPerMin << r_k;
            S_WDAY:  n_sub = DaysPerWeek << r_k;
            S_QUAD:  n_sub = (r_year == ShortQuadYr) ? QuadShort : QuadLong;
            S_YEAR:  n_sub = n_leap ? YearLong : YearShort;
            S_MONTH: n_sub = {27'd0, n_mlen};
            default: n_sub = '0;
        endcase
    end

    // The shared compare-and-subtract unit.
    assign n_ge   = (r_acc >= n_sub);
    assign n_step = n_ge ? (r_acc - n_sub) : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_acc   <= i_secs;
                        r_k     <= 4'd15;
                        r_state <= S_DAY;
                    end
                end
                S_DAY: begin
                    r_acc       <= n_step;
                    r_days[r_k] <= n_ge;
                    if (r_k == 4'd0) begin
                        r_k     <= 4'd4;
                        r_state <= S_HOUR;
                    end else begin
                        r_k <= r_k - 4'd1;
                    end
                end
                S_HOUR: begin
                    r_acc                        <= n_step;
                    r_cal.hour_of_day[r_k[2:0]] <= n_ge;
                    if (r_k == 4'd0) begin
                        r_k     <= 4'd5;
                        r_state <= S_MIN;
                    end else begin
                        r_k <= r_k - 4'd1;
                    end
                end
                S_MIN: begin
                    r_cal.min_of_hour[r_k[2:0]] <= n_ge;
                    if (r_k == 4'd0) begin
                        r_cal.sec_of_minute <= n_step[5:0];
                        r_acc               <= {16'd0, r_days} + EpochWeekday;
                        r_k                 <= 4'd13;
                        r_state             <= S_WDAY;
                    end else begin
                        r_acc <= n_step;
                        r_k   <= r_k - 4'd1;
                    end
                end
                S_WDAY: begin
                    if (r_k == 4'd0) begin
                        r_cal.weekday <= n_step[2:0];
                        r_acc         <= {16'd0, r_days};
                        r_year        <= EpochYear;
                        r_state       <= S_QUAD;
                    end else begin
                        r_acc <= n_step;
                        r_k   <= r_k - 4'd1;
                    end
                end
                S_QUAD: begin
                    if (n_ge) begin
                        r_acc  <= n_step;
                        r_year <= r_year + 12'd4;
                    end else begin
                        r_state <= S_YEAR;
                    end
                end
                S_YEAR: begin
                    if (n_ge) begin
                        r_acc  <= n_step;
                        r_year <= r_year + 12'd1;
                    end else begin
                        r_month <= 4'd0;
                        r_state <= S_MONTH;
                    end
                end
                S_MONTH: begin
                    if (n_ge && (r_month != MonthDec)) begin
                        r_acc   <= n_step;
                        r_month <= r_month + 4'd1;
                    end else begin
                        r_cal.cal_year  <= r_year;
                        r_cal.cal_month <= r_month + 4'd1;
                        r_cal.cal_day   <= r_acc[4:0] + 5'd1;
                        r_state         <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_cal       = r_cal;

endmodule

`default_nettype wire

// ===== src/ms_tick_clock_with_calendar.sv =====
// Top level of the millisecond tick clock with Gregorian calendar readout.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a wrapping 32-bit millisecond count and a wrapping 32-bit
// count of seconds since 1970-01-01 00:00:00, both zero after reset. A tick
// beat adds one millisecond, and each time the new millisecond count is a
// multiple of 1000 (including the wrap to zero) the seconds count advances as
// well; a load beat replaces the seconds count and leaves the milliseconds
// alone. Every input beat yields exactly one output beat with both counts and
// the seconds count broken down into time of day, weekday and an exact
// Gregorian date (with the century rule, so 2100 is not a leap year). One
// beat is handled at a time: a single 32-bit compare-and-subtract unit is
// stepped through the day, hour, minute and weekday divisions (41 steps) and
// then through four-year, year and month subtractions whose number depends
// on the date. The input stalls from acceptance until the result has moved
// into the output register; the next beat may then be accepted while that
// result still waits to be taken.

module ms_tick_clock_with_calendar (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire mtc_pkg::t_in_beat  i_in,
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      mtc_pkg::t_out_beat o_out
);

    localparam logic [mtc_pkg::MsResW-1:0] MsResLast = mtc_pkg::MsResW'(mtc_pkg::MsPerSec - 1);

    // Clock state. The residue counter tracks the millisecond count modulo
    // 1000, so the seconds carry needs no divider.
    logic [31:0]                 r_ms;
    logic [31:0]                 r_secs;
    logic [mtc_pkg::MsResW-1:0]  r_ms_res;

    logic [31:0]                 n_ms;
    logic [31:0]                 n_secs;
    logic [mtc_pkg::MsResW-1:0]  n_ms_res;

    logic                        r_out_valid;
    mtc_pkg::t_out_beat          r_out;

    mtc_pkg::t_conv_stat         conv_stat;
    mtc_pkg::t_cal               conv_cal;
    logic                        in_take;
    logic                        conv_ack;

    assign o_in_stall = conv_stat.busy;
    assign in_take    = i_in_valid && !conv_stat.busy;

    // The finished conversion moves to the output register when that register
    // is empty or is being emptied in the same cycle.
    assign conv_ack = conv_stat.done && (!r_out_valid || !i_out_stall);

    // Next values of the counters for the beat being accepted.
    always_comb begin
        n_ms     = r_ms;
        n_secs   = r_secs;
        n_ms_res = r_ms_res;
        if (i_in.cmd == mtc_pkg::CmdTick) begin
            n_ms = r_ms + 32'd1;
            // The wrap from all ones to zero lands on a multiple of 1000.
            if ((r_ms == '1) || (r_ms_res == MsResLast)) begin
                n_ms_res = '0;
                n_secs   = r_secs + 32'd1;
            end else begin
                n_ms_res = r_ms_res + mtc_pkg::MsResW'(1);
            end
        end else begin
            n_secs = i_in.new_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms        <= '0;
            r_secs      <= '0;
            r_ms_res    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_ms     <= n_ms;
                r_secs   <= n_secs;
                r_ms_res <= n_ms_res;
            end
            // The counters stay put while the converter is busy, so they still
            // belong to the beat whose result is being handed over.
            if (conv_ack) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (conv_ack) begin
            r_out.milli_count   <= r_ms;
            r_out.epoch_seconds <= r_secs;
            r_out.sec_of_minute <= conv_cal.sec_of_minute;
            r_out.min_of_hour   <= conv_cal.min_of_hour;
            r_out.hour_of_day   <= conv_cal.hour_of_day;
            r_out.weekday       <= conv_cal.weekday;
            r_out.cal_year      <= conv_cal.cal_year;
            r_out.cal_month     <= conv_cal.cal_month;
            r_out.cal_day       <= conv_cal.cal_day;
        end
    end

    mtc_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_take),
        .i_secs  (n_secs),
        .i_ack   (conv_ack),
        .o_stat  (conv_stat),
        .o_cal   (conv_cal)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
